// File: rtl/core/ldc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldc_pkg: shared types and constants for the lens distortion correction core
// Fixed-point widths of every pipeline quantity, the CSR index map and the
// round-to-nearest (ties away from zero) helpers.
// ----------------------------------------------------------------------------
package ldc_pkg;

   // Fractional bits of coordinates (Q2.30) and coefficients (Q8.24)
   localparam int Q_COORD = 30;
   localparam int Q_COEF  = 24;

   // CSR map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_K1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_K2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_K3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_P1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_P2 = 3'd4;

   // Split points used to cut wide products into two partial products
   localparam int R2_SPLIT   = 17;
   localparam int R4_SPLIT   = 19;
   localparam int R6_SPLIT   = 21;
   localparam int POLY_SPLIT = 24;

   // Number of register stages in the arithmetic pipeline
   localparam int PIPE_DEPTH = 10;

   // Value types (all signed, sized to the largest magnitude they can hold)
   typedef logic signed [31:0] coord_type;  // Q2.30 points, Q8.24 coefs
   typedef logic signed [63:0] prod_type;   // x*x, y*y, x*y
   typedef logic signed [33:0] sq_type;     // xx, yy, xy    (<= 2^32)
   typedef logic signed [34:0] r2_type;     // r2            (<= 2^33)
   typedef logic signed [34:0] c2_type;     // 2*xy
   typedef logic signed [35:0] ax_type;     // r2 + 2*xx     (<= 2^34)
   typedef logic signed [37:0] r4_type;     // r4            (<= 2^36)
   typedef logic signed [40:0] r6_type;     // r6            (<= 2^39)
   typedef logic signed [47:0] poly_type;   // radial polynomial
   typedef logic signed [43:0] tan_type;    // tangential sum
   typedef logic signed [49:0] rad_type;    // radial term
   typedef logic signed [50:0] tot_type;    // negated total before clamp
   typedef logic signed [79:0] wide_type;   // rounding work width

   // Partial product types
   typedef logic signed [52:0] qp_type;     // r2 * r2 halves
   typedef logic signed [66:0] kp1_type;    // k1 * r2
   typedef logic signed [67:0] tp_type;     // tangential products
   typedef logic signed [54:0] sp_type;     // r2 * r4 halves
   typedef logic signed [51:0] k2p_type;    // k2 * r4 halves
   typedef logic signed [53:0] k3p_type;    // k3 * r6 halves
   typedef logic signed [56:0] xp_type;     // coord * poly halves

   // Coefficient bundle from the CSR block to the datapath
   typedef struct packed {
      coord_type k1;
      coord_type k2;
      coord_type k3;
      coord_type p1;
      coord_type p2;
   } ldc_coef_type;

   localparam coord_type CORR_MAX = 32'sh7FFF_FFFF;
   localparam coord_type CORR_MIN = 32'sh8000_0000;

   localparam wide_type ROUND_COORD = wide_type'(1) <<< (Q_COORD - 1);
   localparam wide_type ROUND_COEF  = wide_type'(1) <<< (Q_COEF - 1);

   // Round p / 2^30 to nearest, ties away from zero
   function automatic wide_type rnd_coord(input wide_type p);
      wide_type bias;
      bias = p[79] ? (ROUND_COORD - wide_type'(1)) : ROUND_COORD;
      return (p + bias) >>> Q_COORD;
   endfunction

   // Round p / 2^24 to nearest, ties away from zero
   function automatic wide_type rnd_coef(input wide_type p);
      wide_type bias;
      bias = p[79] ? (ROUND_COEF - wide_type'(1)) : ROUND_COEF;
      return (p + bias) >>> Q_COEF;
   endfunction

endpackage

// File: rtl/core/ldc_channels_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldc channel interfaces
// Valid/ready channels for input points and for correction results.
// ----------------------------------------------------------------------------
interface ldc_req_if;
   logic                valid;
   logic                ready;
   ldc_pkg::coord_type  coord_x;
   ldc_pkg::coord_type  coord_y;

   modport source (output valid, output coord_x, output coord_y, input ready);
   modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

interface ldc_rsp_if;
   logic                valid;
   logic                ready;
   ldc_pkg::coord_type  corr_x;
   ldc_pkg::coord_type  corr_y;
   logic                overflow;

   modport source (output valid, output corr_x, output corr_y, output overflow,
                   input ready);
   modport sink   (input valid, input corr_x, input corr_y, input overflow,
                   output ready);
endinterface

// File: rtl/core/ldc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldc_csr: coefficient registers
// Holds k1, k2, k3, p1, p2 (signed Q8.24). Writes to unmapped indexes drop.
// ----------------------------------------------------------------------------
module ldc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ldc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  ldc_pkg::coord_type                csr_wdata,
   output ldc_pkg::ldc_coef_type             coef
);

   ldc_pkg::ldc_coef_type coef_ff;
   ldc_pkg::ldc_coef_type coef_in;

   // Register write decode
   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         case (csr_index)
            ldc_pkg::CSR_K1: coef_in.k1 = csr_wdata;
            ldc_pkg::CSR_K2: coef_in.k2 = csr_wdata;
            ldc_pkg::CSR_K3: coef_in.k3 = csr_wdata;
            ldc_pkg::CSR_P1: coef_in.p1 = csr_wdata;
            ldc_pkg::CSR_P2: coef_in.p2 = csr_wdata;
            default:         coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// File: rtl/core/ldc_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldc_pipe: radial and tangential arithmetic pipeline
// Ten register stages. Several wide products are cut into two partial
// products in one stage and summed and rounded in the next. The whole pipe
// moves on advance; valid bits travel with the data.
// ----------------------------------------------------------------------------
module ldc_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  ldc_pkg::coord_type     in_x,
   input  ldc_pkg::coord_type     in_y,
   input  ldc_pkg::ldc_coef_type  coef,
   output logic                   out_valid,
   output ldc_pkg::rad_type       out_radx,
   output ldc_pkg::rad_type       out_rady,
   output ldc_pkg::tan_type       out_tanx,
   output ldc_pkg::tan_type       out_tany
);

   localparam int N = ldc_pkg::PIPE_DEPTH;

   logic [N-1:0] vld_ff;

   // Stage 1: squares and cross product
   ldc_pkg::prod_type  m_xx1_ff, m_yy1_ff, m_xy1_ff;
   ldc_pkg::prod_type  m_xx1_in, m_yy1_in, m_xy1_in;
   ldc_pkg::coord_type x1_ff, y1_ff;
   // Stage 2: rounded squares and r2
   ldc_pkg::sq_type    xx2_ff, yy2_ff, xy2_ff;
   ldc_pkg::sq_type    xx2_in, yy2_in, xy2_in;
   ldc_pkg::r2_type    r2_2_ff, r2_2_in;
   ldc_pkg::coord_type x2_ff, y2_ff;
   // Stage 3: r4 halves, k1*r2, tangential operands
   ldc_pkg::qp_type    q_lo3_ff, q_hi3_ff, q_lo3_in, q_hi3_in;
   ldc_pkg::kp1_type   k1r2_3_ff, k1r2_3_in;
   ldc_pkg::ax_type    ax3_ff, ay3_ff, ax3_in, ay3_in;
   ldc_pkg::c2_type    c2_3_ff, c2_3_in;
   ldc_pkg::r2_type    r2_3_ff;
   ldc_pkg::coord_type x3_ff, y3_ff;
   // Stage 4: r4, first radial term, tangential products
   ldc_pkg::r4_type    r4_4_ff, r4_4_in;
   ldc_pkg::poly_type  t1_4_ff, t1_4_in;
   ldc_pkg::tp_type    tx1_4_ff, tx2_4_ff, ty1_4_ff, ty2_4_ff;
   ldc_pkg::tp_type    tx1_4_in, tx2_4_in, ty1_4_in, ty2_4_in;
   ldc_pkg::r2_type    r2_4_ff;
   ldc_pkg::coord_type x4_ff, y4_ff;
   // Stage 5: r6 halves, k2*r4 halves, tangential sums
   ldc_pkg::sp_type    s_lo5_ff, s_hi5_ff, s_lo5_in, s_hi5_in;
   ldc_pkg::k2p_type   k_lo5_ff, k_hi5_ff, k_lo5_in, k_hi5_in;
   ldc_pkg::tan_type   tanx5_ff, tany5_ff, tanx5_in, tany5_in;
   ldc_pkg::poly_type  t1_5_ff;
   ldc_pkg::coord_type x5_ff, y5_ff;
   // Stage 6: r6 and second radial term
   ldc_pkg::r6_type    r6_6_ff, r6_6_in;
   ldc_pkg::poly_type  t2_6_ff, t2_6_in;
   ldc_pkg::poly_type  t1_6_ff;
   ldc_pkg::tan_type   tanx6_ff, tany6_ff;
   ldc_pkg::coord_type x6_ff, y6_ff;
   // Stage 7: k3*r6 halves, partial polynomial
   ldc_pkg::k3p_type   u_lo7_ff, u_hi7_ff, u_lo7_in, u_hi7_in;
   ldc_pkg::poly_type  pa7_ff, pa7_in;
   ldc_pkg::tan_type   tanx7_ff, tany7_ff;
   ldc_pkg::coord_type x7_ff, y7_ff;
   // Stage 8: full polynomial
   ldc_pkg::poly_type  poly8_ff, poly8_in;
   ldc_pkg::tan_type   tanx8_ff, tany8_ff;
   ldc_pkg::coord_type x8_ff, y8_ff;
   // Stage 9: coord * poly halves
   ldc_pkg::xp_type    vx_lo9_ff, vx_hi9_ff, vy_lo9_ff, vy_hi9_ff;
   ldc_pkg::xp_type    vx_lo9_in, vx_hi9_in, vy_lo9_in, vy_hi9_in;
   ldc_pkg::tan_type   tanx9_ff, tany9_ff;
   // Stage 10: radial terms
   ldc_pkg::rad_type   radx10_ff, rady10_ff, radx10_in, rady10_in;
   ldc_pkg::tan_type   tanx10_ff, tany10_ff;

   // Operand halves for the split multiplies
   logic signed [ldc_pkg::R2_SPLIT:0]       r2_lo;
   logic signed [34-ldc_pkg::R2_SPLIT:0]    r2_hi;
   logic signed [ldc_pkg::R4_SPLIT:0]       r4_lo;
   logic signed [37-ldc_pkg::R4_SPLIT:0]    r4_hi;
   logic signed [ldc_pkg::R6_SPLIT:0]       r6_lo;
   logic signed [40-ldc_pkg::R6_SPLIT:0]    r6_hi;
   logic signed [ldc_pkg::POLY_SPLIT:0]     poly_lo;
   logic signed [47-ldc_pkg::POLY_SPLIT:0]  poly_hi;

   assign r2_lo   = $signed({1'b0, r2_2_ff[ldc_pkg::R2_SPLIT-1:0]});
   assign r2_hi   = $signed(r2_2_ff[34:ldc_pkg::R2_SPLIT]);
   assign r4_lo   = $signed({1'b0, r4_4_ff[ldc_pkg::R4_SPLIT-1:0]});
   assign r4_hi   = $signed(r4_4_ff[37:ldc_pkg::R4_SPLIT]);
   assign r6_lo   = $signed({1'b0, r6_6_ff[ldc_pkg::R6_SPLIT-1:0]});
   assign r6_hi   = $signed(r6_6_ff[40:ldc_pkg::R6_SPLIT]);
   assign poly_lo = $signed({1'b0, poly8_ff[ldc_pkg::POLY_SPLIT-1:0]});
   assign poly_hi = $signed(poly8_ff[47:ldc_pkg::POLY_SPLIT]);

   // Stage 1 and 2 logic
   always_comb begin
      m_xx1_in = ldc_pkg::prod_type'(in_x) * ldc_pkg::prod_type'(in_x);
      m_yy1_in = ldc_pkg::prod_type'(in_y) * ldc_pkg::prod_type'(in_y);
      m_xy1_in = ldc_pkg::prod_type'(in_x) * ldc_pkg::prod_type'(in_y);

      xx2_in  = ldc_pkg::sq_type'(ldc_pkg::rnd_coord(ldc_pkg::wide_type'(m_xx1_ff)));
      yy2_in  = ldc_pkg::sq_type'(ldc_pkg::rnd_coord(ldc_pkg::wide_type'(m_yy1_ff)));
      xy2_in  = ldc_pkg::sq_type'(ldc_pkg::rnd_coord(ldc_pkg::wide_type'(m_xy1_ff)));
      r2_2_in = ldc_pkg::r2_type'(xx2_in) + ldc_pkg::r2_type'(yy2_in);
   end

   // Stage 3 and 4 logic
   always_comb begin
      q_lo3_in  = ldc_pkg::qp_type'(r2_2_ff) * ldc_pkg::qp_type'(r2_lo);
      q_hi3_in  = ldc_pkg::qp_type'(r2_2_ff) * ldc_pkg::qp_type'(r2_hi);
      k1r2_3_in = ldc_pkg::kp1_type'(coef.k1) * ldc_pkg::kp1_type'(r2_2_ff);
      ax3_in    = ldc_pkg::ax_type'(r2_2_ff) + (ldc_pkg::ax_type'(xx2_ff) <<< 1);
      ay3_in    = ldc_pkg::ax_type'(r2_2_ff) + (ldc_pkg::ax_type'(yy2_ff) <<< 1);
      c2_3_in   = ldc_pkg::c2_type'(xy2_ff) <<< 1;

      r4_4_in  = ldc_pkg::r4_type'(ldc_pkg::rnd_coord(
                    (ldc_pkg::wide_type'(q_hi3_ff) <<< ldc_pkg::R2_SPLIT)
                    + ldc_pkg::wide_type'(q_lo3_ff)));
      t1_4_in  = ldc_pkg::poly_type'(ldc_pkg::rnd_coef(ldc_pkg::wide_type'(k1r2_3_ff)));
      tx1_4_in = ldc_pkg::tp_type'(coef.p1) * ldc_pkg::tp_type'(ax3_ff);
      tx2_4_in = ldc_pkg::tp_type'(coef.p2) * ldc_pkg::tp_type'(c2_3_ff);
      ty1_4_in = ldc_pkg::tp_type'(coef.p1) * ldc_pkg::tp_type'(c2_3_ff);
      ty2_4_in = ldc_pkg::tp_type'(coef.p2) * ldc_pkg::tp_type'(ay3_ff);
   end

   // Stage 5 and 6 logic
   always_comb begin
      s_lo5_in = ldc_pkg::sp_type'(r2_4_ff) * ldc_pkg::sp_type'(r4_lo);
      s_hi5_in = ldc_pkg::sp_type'(r2_4_ff) * ldc_pkg::sp_type'(r4_hi);
      k_lo5_in = ldc_pkg::k2p_type'(coef.k2) * ldc_pkg::k2p_type'(r4_lo);
      k_hi5_in = ldc_pkg::k2p_type'(coef.k2) * ldc_pkg::k2p_type'(r4_hi);
      tanx5_in = ldc_pkg::tan_type'(ldc_pkg::rnd_coef(ldc_pkg::wide_type'(tx1_4_ff)))
               + ldc_pkg::tan_type'(ldc_pkg::rnd_coef(ldc_pkg::wide_type'(tx2_4_ff)));
      tany5_in = ldc_pkg::tan_type'(ldc_pkg::rnd_coef(ldc_pkg::wide_type'(ty1_4_ff)))
               + ldc_pkg::tan_type'(ldc_pkg::rnd_coef(ldc_pkg::wide_type'(ty2_4_ff)));

      r6_6_in = ldc_pkg::r6_type'(ldc_pkg::rnd_coord(
                   (ldc_pkg::wide_type'(s_hi5_ff) <<< ldc_pkg::R4_SPLIT)
                   + ldc_pkg::wide_type'(s_lo5_ff)));
      t2_6_in = ldc_pkg::poly_type'(ldc_pkg::rnd_coef(
                   (ldc_pkg::wide_type'(k_hi5_ff) <<< ldc_pkg::R4_SPLIT)
                   + ldc_pkg::wide_type'(k_lo5_ff)));
   end

   // Stage 7 to 10 logic
   always_comb begin
      u_lo7_in = ldc_pkg::k3p_type'(coef.k3) * ldc_pkg::k3p_type'(r6_lo);
      u_hi7_in = ldc_pkg::k3p_type'(coef.k3) * ldc_pkg::k3p_type'(r6_hi);
      pa7_in   = t1_6_ff + t2_6_ff;

      poly8_in = pa7_ff + ldc_pkg::poly_type'(ldc_pkg::rnd_coef(
                    (ldc_pkg::wide_type'(u_hi7_ff) <<< ldc_pkg::R6_SPLIT)
                    + ldc_pkg::wide_type'(u_lo7_ff)));

      vx_lo9_in = ldc_pkg::xp_type'(x8_ff) * ldc_pkg::xp_type'(poly_lo);
      vx_hi9_in = ldc_pkg::xp_type'(x8_ff) * ldc_pkg::xp_type'(poly_hi);
      vy_lo9_in = ldc_pkg::xp_type'(y8_ff) * ldc_pkg::xp_type'(poly_lo);
      vy_hi9_in = ldc_pkg::xp_type'(y8_ff) * ldc_pkg::xp_type'(poly_hi);

      radx10_in = ldc_pkg::rad_type'(ldc_pkg::rnd_coord(
                     (ldc_pkg::wide_type'(vx_hi9_ff) <<< ldc_pkg::POLY_SPLIT)
                     + ldc_pkg::wide_type'(vx_lo9_ff)));
      rady10_in = ldc_pkg::rad_type'(ldc_pkg::rnd_coord(
                     (ldc_pkg::wide_type'(vy_hi9_ff) <<< ldc_pkg::POLY_SPLIT)
                     + ldc_pkg::wide_type'(vy_lo9_ff)));
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   // Payload registers, frozen while the pipe is stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         m_xx1_ff  <= m_xx1_in;
         m_yy1_ff  <= m_yy1_in;
         m_xy1_ff  <= m_xy1_in;
         x1_ff     <= in_x;
         y1_ff     <= in_y;

         xx2_ff    <= xx2_in;
         yy2_ff    <= yy2_in;
         xy2_ff    <= xy2_in;
         r2_2_ff   <= r2_2_in;
         x2_ff     <= x1_ff;
         y2_ff     <= y1_ff;

         q_lo3_ff  <= q_lo3_in;
         q_hi3_ff  <= q_hi3_in;
         k1r2_3_ff <= k1r2_3_in;
         ax3_ff    <= ax3_in;
         ay3_ff    <= ay3_in;
         c2_3_ff   <= c2_3_in;
         r2_3_ff   <= r2_2_ff;
         x3_ff     <= x2_ff;
         y3_ff     <= y2_ff;

         r4_4_ff   <= r4_4_in;
         t1_4_ff   <= t1_4_in;
         tx1_4_ff  <= tx1_4_in;
         tx2_4_ff  <= tx2_4_in;
         ty1_4_ff  <= ty1_4_in;
         ty2_4_ff  <= ty2_4_in;
         r2_4_ff   <= r2_3_ff;
         x4_ff     <= x3_ff;
         y4_ff     <= y3_ff;

         s_lo5_ff  <= s_lo5_in;
         s_hi5_ff  <= s_hi5_in;
         k_lo5_ff  <= k_lo5_in;
         k_hi5_ff  <= k_hi5_in;
         tanx5_ff  <= tanx5_in;
         tany5_ff  <= tany5_in;
         t1_5_ff   <= t1_4_ff;
         x5_ff     <= x4_ff;
         y5_ff     <= y4_ff;

         r6_6_ff   <= r6_6_in;
         t2_6_ff   <= t2_6_in;
         t1_6_ff   <= t1_5_ff;
         tanx6_ff  <= tanx5_ff;
         tany6_ff  <= tany5_ff;
         x6_ff     <= x5_ff;
         y6_ff     <= y5_ff;

         u_lo7_ff  <= u_lo7_in;
         u_hi7_ff  <= u_hi7_in;
         pa7_ff    <= pa7_in;
         tanx7_ff  <= tanx6_ff;
         tany7_ff  <= tany6_ff;
         x7_ff     <= x6_ff;
         y7_ff     <= y6_ff;

         poly8_ff  <= poly8_in;
         tanx8_ff  <= tanx7_ff;
         tany8_ff  <= tany7_ff;
         x8_ff     <= x7_ff;
         y8_ff     <= y7_ff;

         vx_lo9_ff <= vx_lo9_in;
         vx_hi9_ff <= vx_hi9_in;
         vy_lo9_ff <= vy_lo9_in;
         vy_hi9_ff <= vy_hi9_in;
         tanx9_ff  <= tanx8_ff;
         tany9_ff  <= tany8_ff;

         radx10_ff <= radx10_in;
         rady10_ff <= rady10_in;
         tanx10_ff <= tanx9_ff;
         tany10_ff <= tany9_ff;
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_radx  = radx10_ff;
   assign out_rady  = rady10_ff;
   assign out_tanx  = tanx10_ff;
   assign out_tany  = tany10_ff;

   // A stall freezes every valid bit
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipe valid bits moved during a stall");

   // On advance every valid bit moves exactly one stage
   a_advance_shifts: assert property (@(posedge clock) disable iff (reset)
      advance |=> (vld_ff[N-1:1] == $past(vld_ff[N-2:0])))
      else $error("pipe valid bits lost or duplicated on advance");

endmodule

// File: rtl/core/ldc_sat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldc_sat: final sum, negation and saturation
// Adds radial and tangential terms, negates, clamps to Q2.30 and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module ldc_sat (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  ldc_pkg::rad_type    radx,
   input  ldc_pkg::rad_type    rady,
   input  ldc_pkg::tan_type    tanx,
   input  ldc_pkg::tan_type    tany,
   output logic                out_valid,
   output ldc_pkg::coord_type  corr_x,
   output ldc_pkg::coord_type  corr_y,
   output logic                overflow
);

   ldc_pkg::tot_type   tot_x, tot_y;
   logic               hi_x, lo_x, hi_y, lo_y;
   logic               out_valid_ff;
   ldc_pkg::coord_type corr_x_ff, corr_y_ff, corr_x_in, corr_y_in;
   logic               overflow_ff, overflow_in;

   // Negated totals and clamp
   always_comb begin
      tot_x = -(ldc_pkg::tot_type'(radx) + ldc_pkg::tot_type'(tanx));
      tot_y = -(ldc_pkg::tot_type'(rady) + ldc_pkg::tot_type'(tany));
      hi_x  = tot_x > ldc_pkg::tot_type'(ldc_pkg::CORR_MAX);
      lo_x  = tot_x < ldc_pkg::tot_type'(ldc_pkg::CORR_MIN);
      hi_y  = tot_y > ldc_pkg::tot_type'(ldc_pkg::CORR_MAX);
      lo_y  = tot_y < ldc_pkg::tot_type'(ldc_pkg::CORR_MIN);

      if (hi_x) begin
         corr_x_in = ldc_pkg::CORR_MAX;
      end else if (lo_x) begin
         corr_x_in = ldc_pkg::CORR_MIN;
      end else begin
         corr_x_in = ldc_pkg::coord_type'(tot_x);
      end

      if (hi_y) begin
         corr_y_in = ldc_pkg::CORR_MAX;
      end else if (lo_y) begin
         corr_y_in = ldc_pkg::CORR_MIN;
      end else begin
         corr_y_in = ldc_pkg::coord_type'(tot_y);
      end

      overflow_in = hi_x | lo_x | hi_y | lo_y;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         corr_x_ff   <= corr_x_in;
         corr_y_ff   <= corr_y_in;
         overflow_ff <= overflow_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign corr_x    = corr_x_ff;
   assign corr_y    = corr_y_ff;
   assign overflow  = overflow_ff;

   // A flagged result must carry at least one clamped correction
   a_ovf_clamped: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && overflow_ff) |->
         (corr_x_ff == ldc_pkg::CORR_MAX || corr_x_ff == ldc_pkg::CORR_MIN ||
          corr_y_ff == ldc_pkg::CORR_MAX || corr_y_ff == ldc_pkg::CORR_MIN))
      else $error("overflow set without a clamped correction");

endmodule

// File: rtl/core/lens_distortion_correction_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_distortion_correction_core: Brown-Conrady correction, k1 k2 k3 p1 p2
// Takes one normalized point (Q2.30) per transaction and returns the negated
// radial plus tangential correction for x and y, saturated to Q2.30, with an
// overflow flag.
// ----------------------------------------------------------------------------
// One point is accepted every clock cycle unless stalled; results pass the
// ten arithmetic stages (several wide products are formed as two partial
// products and rounded one stage later) and the output register. req_if.ready
// is high whenever the output register is empty or is being taken; a stall
// on rsp_if freezes the whole pipeline, nothing is lost or repeated. The user
// must write coefficients through the csr_ port only while no transaction
// is in flight, unchecked by the core; they take effect for the next point.
module lens_distortion_correction_core (
   input  logic                            clock,
   input  logic                            reset,
   ldc_req_if.sink                         req_if,
   ldc_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [ldc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  ldc_pkg::coord_type              csr_wdata
);

   ldc_pkg::ldc_coef_type coef;
   logic                  advance;
   logic                  pipe_valid;
   ldc_pkg::rad_type      pipe_radx, pipe_rady;
   ldc_pkg::tan_type      pipe_tanx, pipe_tany;

   // Whole pipe moves when the output register is free or being drained
   assign advance      = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = advance;

   ldc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   ldc_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_if.valid),
      .in_x      (req_if.coord_x),
      .in_y      (req_if.coord_y),
      .coef      (coef),
      .out_valid (pipe_valid),
      .out_radx  (pipe_radx),
      .out_rady  (pipe_rady),
      .out_tanx  (pipe_tanx),
      .out_tany  (pipe_tany)
   );

   ldc_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pipe_valid),
      .radx      (pipe_radx),
      .rady      (pipe_rady),
      .tanx      (pipe_tanx),
      .tany      (pipe_tany),
      .out_valid (rsp_if.valid),
      .corr_x    (rsp_if.corr_x),
      .corr_y    (rsp_if.corr_y),
      .overflow  (rsp_if.overflow)
   );

endmodule

// File: tb/lens_distortion_correction_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_distortion_correction_core_tb: self-checking bench for the LDC core
// Drives normalized points through the request channel under several
// coefficient settings and compares every correction transaction, field by
// field, with a bit-exact fixed-point Brown-Conrady predictor kept in the
// bench. Random sender gaps and receiver stalls exercise the handshake.
// ----------------------------------------------------------------------------
module lens_distortion_correction_core_tb;
   import ldc_pkg::*;

   localparam int        PERIOD_NS    = 10;
   localparam int        LIMIT_NS     = 5_000_000;
   localparam int        PHASE_POINTS = 66;
   localparam int        NUM_PHASES   = 6;
   localparam coord_type WORD_MAX     = 32'sh7FFF_FFFF;
   localparam coord_type WORD_MIN     = 32'sh8000_0000;
   localparam coord_type ONE_Q30      = 32'sh4000_0000;
   localparam coord_type HALF_Q30     = 32'sh2000_0000;
   // points mostly kept within +/-1.25 of the optical center
   localparam logic [31:0] NEAR_HALF  = 32'd1342177280;
   localparam logic [31:0] NEAR_SPAN  = 32'd2684354560;

   typedef enum int {
      COEF_REALISTIC,
      COEF_FULL,
      COEF_EXTREME,
      COEF_TINY
   } coef_style_e;

   typedef struct {
      coord_type x;
      coord_type y;
   } point_item;

   typedef struct {
      coord_type corr_x;
      coord_type corr_y;
      logic      overflow;
   } corr_item;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   coord_type            csr_wdata;

   ldc_req_if req_bus ();
   ldc_rsp_if rsp_bus ();

   // bench copy of the coefficient registers
   coord_type coef_k1 = '0;
   coord_type coef_k2 = '0;
   coord_type coef_k3 = '0;
   coord_type coef_p1 = '0;
   coord_type coef_p2 = '0;

   point_item pending_points[$];
   corr_item  expected_corrections[$];
   int        points_outstanding = 0;
   int        mismatch_count     = 0;
   bit        idling_on          = 1'b1;
   int        send_gap           = 0;
   int        hold_cycles        = 0;

   lens_distortion_correction_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(PERIOD_NS / 2) clock = ~clock;

   // round(a*b / 2^shift), ties away from zero, magnitude capped at 2^62
   function automatic longint round_product(input longint a, input longint b,
                                            input int unsigned shift);
      logic [63:0]  mag_a;
      logic [63:0]  mag_b;
      logic [127:0] full;
      logic [127:0] scaled;
      longint       mag;
      mag_a  = (a < 0) ? 64'(-a) : 64'(a);
      mag_b  = (b < 0) ? 64'(-b) : 64'(b);
      full   = {64'd0, mag_a} * {64'd0, mag_b};
      full   = full + (128'd1 << (shift - 1));
      scaled = full >> shift;
      if (scaled > (128'd1 << 62))
         scaled = 128'd1 << 62;
      mag = longint'(scaled[63:0]);
      return ((a < 0) != (b < 0)) ? -mag : mag;
   endfunction

   function automatic coord_type clamp_q30(input longint total, output logic clipped);
      clipped = 1'b1;
      if (total > longint'(WORD_MAX))
         return WORD_MAX;
      if (total < longint'(WORD_MIN))
         return WORD_MIN;
      clipped = 1'b0;
      return coord_type'(total);
   endfunction

   // negated radial + tangential correction for one point
   function automatic corr_item brown_conrady_correction(input coord_type x,
                                                         input coord_type y);
      longint   px, py, xx, yy, xy2, r2, r4, r6, poly;
      longint   rad_x, rad_y, tan_x, tan_y;
      logic     clip_x, clip_y;
      corr_item res;
      px    = longint'(x);
      py    = longint'(y);
      xx    = round_product(px, px, Q_COORD);
      yy    = round_product(py, py, Q_COORD);
      xy2   = 2 * round_product(px, py, Q_COORD);
      r2    = xx + yy;
      r4    = round_product(r2, r2, Q_COORD);
      r6    = round_product(r4, r2, Q_COORD);
      poly  = round_product(longint'(coef_k1), r2, Q_COEF)
            + round_product(longint'(coef_k2), r4, Q_COEF)
            + round_product(longint'(coef_k3), r6, Q_COEF);
      rad_x = round_product(px, poly, Q_COORD);
      rad_y = round_product(py, poly, Q_COORD);
      tan_x = round_product(longint'(coef_p1), r2 + 2 * xx, Q_COEF)
            + round_product(longint'(coef_p2), xy2, Q_COEF);
      tan_y = round_product(longint'(coef_p1), xy2, Q_COEF)
            + round_product(longint'(coef_p2), r2 + 2 * yy, Q_COEF);
      res.corr_x   = clamp_q30(-(rad_x + tan_x), clip_x);
      res.corr_y   = clamp_q30(-(rad_y + tan_y), clip_y);
      res.overflow = clip_x | clip_y;
      return res;
   endfunction

   // register write as seen by the bench copy; unmapped indexes do nothing
   function automatic void note_coefficient(input logic [CSR_IDX_W-1:0] idx,
                                            input coord_type value);
      case (idx)
         CSR_K1:  coef_k1 = value;
         CSR_K2:  coef_k2 = value;
         CSR_K3:  coef_k3 = value;
         CSR_P1:  coef_p1 = value;
         CSR_P2:  coef_p2 = value;
         default: ;
      endcase
   endfunction

   function automatic coord_type pick_coefficient(input coef_style_e style);
      case (style)
         COEF_FULL:  return coord_type'($urandom);
         COEF_TINY:  return coord_type'($urandom_range(0, 335544) - 32'd167772);
         COEF_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return WORD_MAX;
               1:       return WORD_MIN;
               2:       return '0;
               default: return coord_type'($urandom);
            endcase
         end
         default:    return coord_type'($urandom_range(0, 32'd33554432) - 32'd16777216);
      endcase
   endfunction

   function automatic coord_type random_coord();
      if ($urandom_range(0, 3) == 0)
         return coord_type'($urandom);
      return coord_type'($urandom_range(0, NEAR_SPAN) - NEAR_HALF);
   endfunction

   task automatic queue_point(input coord_type x, input coord_type y);
      point_item pt;
      pt.x = x;
      pt.y = y;
      pending_points.push_back(pt);
      points_outstanding++;
   endtask

   // edge-of-range and unit points, taken in slices per coefficient setting
   task automatic queue_probes(input int first, input int count);
      for (int i = first; i < first + count; i++) begin
         case (i % 12)
            0:  queue_point('0, '0);
            1:  queue_point(WORD_MAX, WORD_MIN);
            2:  queue_point(WORD_MIN, WORD_MAX);
            3:  queue_point(WORD_MAX, WORD_MAX);
            4:  queue_point(WORD_MIN, WORD_MIN);
            5:  queue_point(ONE_Q30, '0);
            6:  queue_point('0, ONE_Q30);
            7:  queue_point(-ONE_Q30, ONE_Q30);
            8:  queue_point(32'sd1, -32'sd1);
            9:  queue_point(HALF_Q30, -HALF_Q30);
            10: queue_point(32'sh5555_5555, 32'shAAAA_AAAA);
            default: queue_point(32'sh0000_FFFF, 32'shFFFF_0000);
         endcase
      end
   endtask

   task automatic wait_for_results();
      while (points_outstanding != 0)
         @(posedge clock);
   endtask

   // program all five coefficients back to back, optionally hitting the
   // unmapped indexes too; the core must be idle
   task automatic load_coefficients(input coord_type k1, input coord_type k2,
                                    input coord_type k3, input coord_type p1,
                                    input coord_type p2, input bit with_spares);
      coord_type            values [5];
      logic [CSR_IDX_W-1:0] indexes [5];
      coord_type            junk;
      values  = '{k1, k2, k3, p1, p2};
      indexes = '{CSR_K1, CSR_K2, CSR_K3, CSR_P1, CSR_P2};
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= indexes[i];
         csr_wdata <= values[i];
         note_coefficient(indexes[i], values[i]);
      end
      if (with_spares) begin
         for (int s = int'(CSR_P2) + 1; s < (1 << CSR_IDX_W); s++) begin
            junk = coord_type'($urandom);
            @(posedge clock);
            csr_we    <= 1'b1;
            csr_index <= CSR_IDX_W'(s);
            csr_wdata <= junk;
            note_coefficient(CSR_IDX_W'(s), junk);
         end
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // request driver: predicts on acceptance, then presents the next point
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_corrections.push_back(
               brown_conrady_correction(req_bus.coord_x, req_bus.coord_y));
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (idling_on && pending_points.size() != 0
                         && $urandom_range(0, 4) == 0) begin
               send_gap = $urandom_range(0, 15);
               req_bus.valid <= 1'b0;
            end else if (pending_points.size() != 0) begin
               point_item pt;
               pt = pending_points.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.coord_x <= pt.x;
               req_bus.coord_y <= pt.y;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // correction monitor: checks each transaction, then decides on a stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_corrections.size() == 0) begin
               $error("unexpected correction: corr_x=%h corr_y=%h overflow=%b",
                      rsp_bus.corr_x, rsp_bus.corr_y, rsp_bus.overflow);
               mismatch_count++;
            end else begin
               corr_item want;
               want = expected_corrections.pop_front();
               if (rsp_bus.corr_x !== want.corr_x) begin
                  $error("corr_x: expected %h, actual %h", want.corr_x, rsp_bus.corr_x);
                  mismatch_count++;
               end
               if (rsp_bus.corr_y !== want.corr_y) begin
                  $error("corr_y: expected %h, actual %h", want.corr_y, rsp_bus.corr_y);
                  mismatch_count++;
               end
               if (rsp_bus.overflow !== want.overflow) begin
                  $error("overflow: expected %b, actual %b", want.overflow,
                         rsp_bus.overflow);
                  mismatch_count++;
               end
               points_outstanding--;
            end
         end
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            hold_cycles = $urandom_range(0, 15);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // hard stop
   initial begin
      #(LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // stimulus sequence
   initial begin
      coef_style_e style;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.coord_x = '0;
      req_bus.coord_y = '0;
      rsp_bus.ready   = 1'b0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: every correction is zero
      queue_probes(0, 3);
      wait_for_results();

      // typical lens; unmapped register writes must not disturb anything
      load_coefficients(-32'sd5033165, 32'sd1677722, -32'sd167772, 32'sd16777,
                        -32'sd8389, 1'b1);
      queue_probes(0, 10);
      wait_for_results();

      // coefficient extremes, saturation on large radii
      load_coefficients(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
      queue_probes(1, 6);
      wait_for_results();
      load_coefficients(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0);
      queue_probes(5, 6);
      wait_for_results();

      // random phases; the sender holds off at each boundary until drained
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            1:       style = COEF_FULL;
            3:       style = COEF_EXTREME;
            4:       style = COEF_TINY;
            default: style = COEF_REALISTIC;
         endcase
         idling_on = (phase != 2) && (phase != NUM_PHASES - 1);
         load_coefficients(pick_coefficient(style), pick_coefficient(style),
                           pick_coefficient(style), pick_coefficient(style),
                           pick_coefficient(style), phase == 4);
         for (int n = 0; n < PHASE_POINTS; n++)
            queue_point(random_coord(), random_coord());
         wait_for_results();
      end

      // let any stray transaction show up before the verdict
      repeat (2 * (PIPE_DEPTH + 1)) @(posedge clock);
      if (mismatch_count == 0 && expected_corrections.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: lens_distortion_correction_core.f
rtl/core/ldc_pkg.sv
rtl/core/ldc_channels_if.sv
rtl/core/ldc_csr.sv
rtl/core/ldc_pipe.sv
rtl/core/ldc_sat.sv
rtl/core/lens_distortion_correction_core.sv
tb/lens_distortion_correction_core_tb.sv
